/* sv/ksel_pkg.sv */
// shared types and constants of the k smallest selector
package ksel_pkg;

    // data and register widths
    localparam int VALUE_W = 32;
    localparam int KEEP_W  = 5;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // default depth of the cell chain
    localparam int K_MAX_DEFAULT = 16;

    // register map
    localparam logic [ADDR_W-1:0] ADDR_KEEP_COUNT = 3'h0;
    localparam logic [KEEP_W-1:0] KEEP_COUNT_RESET = 5'd16;

    // sequencer states
    typedef enum logic
    {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    // per-cycle control broadcast to every cell
    typedef struct packed
    {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

/* sv/k_smallest_selector.sv */
// top level: chain of sorting cells, drain sequencer and register port
//
//  channel  | signals                                    | timing
//  ---------+--------------------------------------------+-----------------------------
//  request  | start, busy, sample_value, set_end         | taken when start & !busy
//  result   | result_strobe, kept_value, run_end         | one cycle each, no stall
//  config   | psel, penable, pwrite, paddr, pwdata, ...  | write when penable, pready high
//
// a request is taken every cycle while values of a set are collected; each
// cell compares the new value in parallel and the whole chain shifts together.
// on a set end (with keep_count non-zero) busy is high while the chain shifts
// upwards; results appear at the top cell, largest first.
// reset empties the chain and sets keep_count to 16.
// the receiver cannot stall: every result is taken in the cycle it is shown.
module k_smallest_selector
    import ksel_pkg::*;
#(
    parameter int K_MAX = K_MAX_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [VALUE_W-1:0]  sample_value,
    input  logic                       set_end,
    output logic                       result_strobe,
    output logic signed [VALUE_W-1:0]  kept_value,
    output logic                       run_end,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    state_t                    state_reg;
    state_t                    state_next;
    logic [KEEP_W-1:0]         keep_count_reg;
    logic [KEEP_W-1:0]         keep_count_next;
    logic                      accept;
    logic                      last_left;
    cell_ctrl_t                ctrl;

    logic signed [VALUE_W-1:0] cell_value [K_MAX];
    logic                      cell_valid [K_MAX];
    logic                      cell_gt    [K_MAX];
    logic                      cell_limit [K_MAX];

    // register port
    assign pready = 1'b1;

    always_comb
    begin
        keep_count_next = keep_count_reg;
        if (psel && penable && pwrite && (paddr == ADDR_KEEP_COUNT))
        begin
            keep_count_next = pwdata[KEEP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_KEEP_COUNT)
        begin
            prdata = {{(DATA_W-KEEP_W){1'b0}}, keep_count_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KEEP_COUNT_RESET;
        end
        else
        begin
            keep_count_reg <= keep_count_next;
        end
    end

    // request handshake
    assign accept = start && !busy;

    // cell chain, cell 0 holds the smallest value
    genvar i;
    generate
        for (i = 0; i < K_MAX; i++)
        begin : g_cell
            localparam int unsigned IDX = i;

            assign cell_limit[i] = (32'(keep_count_reg) > IDX);

            if (i == 0)
            begin : g_first
                ksel_cell u_cell
                (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .limit      (cell_limit[i]),
                    .in_value   (sample_value),
                    .prev_value (sample_value),
                    .prev_valid (ctrl.insert),
                    .prev_gt    (1'b0),
                    .value      (cell_value[i]),
                    .valid      (cell_valid[i]),
                    .gt         (cell_gt[i])
                );
            end
            else
            begin : g_rest
                ksel_cell u_cell
                (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .limit      (cell_limit[i]),
                    .in_value   (sample_value),
                    .prev_value (cell_value[i-1]),
                    .prev_valid (cell_valid[i-1]),
                    .prev_gt    (cell_gt[i-1]),
                    .value      (cell_value[i]),
                    .valid      (cell_valid[i]),
                    .gt         (cell_gt[i])
                );
            end
        end

        // no value left below the top cell
        if (K_MAX > 1)
        begin : g_last_multi
            assign last_left = !cell_valid[K_MAX-2];
        end
        else
        begin : g_last_single
            assign last_left = 1'b1;
        end
    endgenerate

    // results come off the top of the chain
    assign kept_value    = cell_value[K_MAX-1];
    assign result_strobe = (state_reg == ST_DRAIN) && cell_valid[K_MAX-1];
    assign run_end       = result_strobe && last_left;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (accept && set_end && (keep_count_reg != '0))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (run_end)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        busy        = 1'b0;
        ctrl.insert = 1'b0;
        ctrl.shift  = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                ctrl.insert = accept;
            end
            ST_DRAIN:
            begin
                busy       = 1'b1;
                ctrl.shift = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/ksel_cell.sv */
// one cell of the sorted chain: holds one value and its valid flag
module ksel_cell
    import ksel_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_ctrl_t                 ctrl,
    input  logic                       limit,
    input  logic signed [VALUE_W-1:0]  in_value,
    input  logic signed [VALUE_W-1:0]  prev_value,
    input  logic                       prev_valid,
    input  logic                       prev_gt,
    output logic signed [VALUE_W-1:0]  value,
    output logic                       valid,
    output logic                       gt
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      valid_reg;
    logic                      valid_next;

    // new request goes at or below this cell when the cell is empty or larger
    assign gt = !valid_reg || (value_reg > in_value);

    // insert keeps the chain sorted, shift moves everything one place up
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert)
        begin
            if (gt)
            begin
                value_next = prev_gt ? prev_value : in_value;
            end
            valid_next = limit && (valid_reg || prev_valid);
        end
        else if (ctrl.shift)
        begin
            value_next = prev_value;
            valid_next = prev_valid;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // held value
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule
